### rtl/pll_feedback_divider_params_assert.svh
// Assertion macros for the PLL feedback divider parameter block
`ifndef PLL_FEEDBACK_DIVIDER_PARAMS_ASSERT_SVH
`define PLL_FEEDBACK_DIVIDER_PARAMS_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define PFDP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the next cycle
`define PFDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pfdp_pkg.sv
// Package: constants, pipeline types and the divider step function
package pfdp_pkg;

  localparam int unsigned XtalW   = 26;
  localparam int unsigned FracW   = 20;
  localparam int unsigned QuotW   = 33;
  localparam int unsigned ProdW   = XtalW + FracW;
  localparam int unsigned XmW     = XtalW + 8;

  localparam logic [7:0]       MULT_MIN   = 8'd15;
  localparam logic [7:0]       MULT_MAX   = 8'd90;
  localparam logic [31:0]      FRAC_MAX   = 32'h000F_FFFF;
  localparam logic [7:0]       BASE_PLL_A = 8'd26;
  localparam logic [7:0]       BASE_PLL_B = 8'd34;
  localparam logic [XtalW-1:0] XTAL_RESET = 26'd25000000;
  localparam logic [17:0]      P1_OFFSET  = 18'd512;

  // Entry stage after the multipliers
  typedef struct packed {
    logic             vld;
    logic             bad;
    logic             sel;
    logic             a_rdy;
    logic             b_rdy;
    logic [7:0]       mult;
    logic [FracW-1:0] num;
    logic [FracW-1:0] denom;
    logic [XmW-1:0]   xm;
    logic [ProdW-1:0] xn;
  } s0_t;

  // One divider stage: two long divisions side by side
  typedef struct packed {
    logic             vld;
    logic             bad;
    logic             sel;
    logic             a_rdy;
    logic             b_rdy;
    logic [7:0]       mult;
    logic [FracW-1:0] denom;
    logic [FracW-1:0] rem_a;
    logic [QuotW-1:0] dq_a;
    logic [FracW-1:0] rem_b;
    logic [QuotW-1:0] dq_b;
    logic             sat;
    logic [XmW-1:0]   xm;
  } div_t;

  // Retire one quotient bit of each division
  function automatic div_t div_step(div_t d);
    logic [FracW:0] ta;
    logic [FracW:0] tb;
    logic [FracW:0] da;
    logic [FracW:0] db;
    div_t r;
    r  = d;
    ta = {d.rem_a, d.dq_a[QuotW-1]};
    tb = {d.rem_b, d.dq_b[QuotW-1]};
    da = ta - {1'b0, d.denom};
    db = tb - {1'b0, d.denom};
    if (ta >= {1'b0, d.denom}) begin
      r.rem_a = da[FracW-1:0];
      r.dq_a  = {d.dq_a[QuotW-2:0], 1'b1};
    end else begin
      r.rem_a = ta[FracW-1:0];
      r.dq_a  = {d.dq_a[QuotW-2:0], 1'b0};
    end
    if (tb >= {1'b0, d.denom}) begin
      r.rem_b = db[FracW-1:0];
      r.dq_b  = {d.dq_b[QuotW-2:0], 1'b1};
    end else begin
      r.rem_b = tb[FracW-1:0];
      r.dq_b  = {d.dq_b[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/pll_feedback_divider_params.sv
// PLL feedback divider parameter block: checks, divides and packs register bytes
//
// Input channel in_valid/in_ready carries pll_select, mult, num and denom.
// Result channel out_valid/out_ready carries status, base_register,
// register_bytes, vco_freq_hz and the two PLL ready flags.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the crystal frequency;
// always ready. The user must write it only while the block is idle (unenforced).
// One item enters per cycle unless the receiver stalls; after its beat is
// accepted, the beat lands in the multiplier stage at the accepting edge,
// then 33 restoring-divider stages retire one quotient bit each of
// 128*num/denom and crystal*num/denom, and one output stage forms P1, P2,
// P3 and the VCO frequency.
// Ready flags are updated as an item enters, so results show them in order.
// When the receiver stalls the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
// Reset clears the ready flags, the stored frequencies and all stage valid
// bits, and loads the crystal frequency with 25 MHz.
module pll_feedback_divider_params (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pll_select,
  input  logic [7:0]  mult,
  input  logic [31:0] num,
  input  logic [31:0] denom,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [7:0]  base_register,
  output logic [63:0] register_bytes,
  output logic [31:0] vco_freq_hz,
  output logic        pll_a_ready,
  output logic        pll_b_ready
);

  `include "pll_feedback_divider_params_assert.svh"

  localparam int unsigned Stages = pfdp_pkg::QuotW;

  logic [pfdp_pkg::XtalW-1:0] crystal_freq_hz;
  logic                       pll_a_configured;
  logic                       pll_b_configured;
  logic [31:0]                pll_a_frequency;
  logic [31:0]                pll_b_frequency;

  pfdp_pkg::s0_t  s0;
  pfdp_pkg::div_t dv [1:Stages];
  pfdp_pkg::div_t d0;
  pfdp_pkg::div_t dl;

  logic        adv;
  logic        bad_in;
  logic        a_next;
  logic        b_next;
  logic [17:0] p1;
  logic [19:0] p2;
  logic [19:0] p3;
  logic [34:0] vsum;
  logic [31:0] vco;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  // Check arguments and work out the flags after this item
  always_comb begin
    bad_in = (mult < pfdp_pkg::MULT_MIN) || (mult > pfdp_pkg::MULT_MAX) ||
             (denom == 32'd0) || (num > pfdp_pkg::FRAC_MAX) ||
             (denom > pfdp_pkg::FRAC_MAX);
    a_next = pll_a_configured || (!bad_in && !pll_select);
    b_next = pll_b_configured || (!bad_in && pll_select);
  end

  // Hold configuration and PLL state
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_freq_hz  <= pfdp_pkg::XTAL_RESET;
      pll_a_configured <= 1'b0;
      pll_b_configured <= 1'b0;
      pll_a_frequency  <= 32'd0;
      pll_b_frequency  <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        crystal_freq_hz <= cfg_data;
      end
      if (in_valid && in_ready) begin
        pll_a_configured <= a_next;
        pll_b_configured <= b_next;
      end
      if (out_valid && out_ready && !status) begin
        if (base_register == pfdp_pkg::BASE_PLL_B) begin
          pll_b_frequency <= vco_freq_hz;
        end else begin
          pll_a_frequency <= vco_freq_hz;
        end
      end
    end
  end

  // Entry stage: register the two crystal products
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld <= 1'b0;
    end else if (adv) begin
      s0.vld   <= in_valid;
      s0.bad   <= bad_in;
      s0.sel   <= pll_select;
      s0.a_rdy <= a_next;
      s0.b_rdy <= b_next;
      s0.mult  <= mult;
      s0.num   <= num[pfdp_pkg::FracW-1:0];
      s0.denom <= denom[pfdp_pkg::FracW-1:0];
      s0.xm    <= {8'd0, crystal_freq_hz} * {26'd0, mult};
      s0.xn    <= {20'd0, crystal_freq_hz} * {26'd0, num[pfdp_pkg::FracW-1:0]};
    end
  end

  // Seed both long divisions
  always_comb begin
    d0       = '0;
    d0.vld   = s0.vld;
    d0.bad   = s0.bad;
    d0.sel   = s0.sel;
    d0.a_rdy = s0.a_rdy;
    d0.b_rdy = s0.b_rdy;
    d0.mult  = s0.mult;
    d0.denom = s0.denom;
    d0.rem_a = '0;
    d0.dq_a  = {6'd0, s0.num, 7'd0};
    d0.rem_b = {7'd0, s0.xn[pfdp_pkg::ProdW-1:Stages]};
    d0.dq_b  = s0.xn[Stages-1:0];
    d0.sat   = {7'd0, s0.xn[pfdp_pkg::ProdW-1:Stages]} >= s0.denom;
    d0.xm    = s0.xm;
  end

  // Advance the divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= Stages; k++) begin
        dv[k].vld <= 1'b0;
      end
    end else if (adv) begin
      dv[1] <= pfdp_pkg::div_step(d0);
      for (int k = 2; k <= Stages; k++) begin
        dv[k] <= pfdp_pkg::div_step(dv[k-1]);
      end
    end
  end

  // Form P1, P2, P3 and the saturated VCO frequency
  always_comb begin
    dl   = dv[Stages];
    p1   = {3'd0, dl.mult, 7'd0} - pfdp_pkg::P1_OFFSET + dl.dq_a[17:0];
    p2   = dl.rem_a;
    p3   = dl.denom;
    vsum = {1'b0, dl.xm} + {2'b00, dl.dq_b};
    vco  = (dl.sat || (vsum[34:32] != 3'd0)) ? 32'hFFFF_FFFF : vsum[31:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid     <= dl.vld;
      status        <= dl.bad;
      base_register <= dl.sel ? pfdp_pkg::BASE_PLL_B : pfdp_pkg::BASE_PLL_A;
      pll_a_ready   <= dl.a_rdy;
      pll_b_ready   <= dl.b_rdy;
      if (dl.bad) begin
        register_bytes <= 64'd0;
        vco_freq_hz    <= 32'd0;
      end else begin
        register_bytes <= {p3[15:8], p3[7:0], 6'd0, p1[17:16], p1[15:8], p1[7:0],
                           p3[19:16], p2[19:16], p2[15:8], p2[7:0]};
        vco_freq_hz    <= vco;
      end
    end
  end

  `PFDP_ASSERT_ALWAYS(a_bad_zero,
    !(out_valid && status) || (register_bytes == 64'd0 && vco_freq_hz == 32'd0),
    "rejected item carries nonzero payload")
  `PFDP_ASSERT_ALWAYS(a_good_flag,
    !(out_valid && !status) ||
    (base_register == pfdp_pkg::BASE_PLL_A ? pll_a_ready : pll_b_ready),
    "accepted item without its ready flag")
  `PFDP_ASSERT_NEXT(a_flag_sticky, pll_a_configured || pll_b_configured,
    ($past(pll_a_configured) ? pll_a_configured : 1'b1) &&
    ($past(pll_b_configured) ? pll_b_configured : 1'b1),
    "configured flag cleared outside reset")

endmodule
